/* rtl/core/glob_wildcard_match_defines.svh */
// ----------------------------------------------------------------------------
// glob_wildcard_match assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCH_DEFINES_SVH
`define GLOB_WILDCARD_MATCH_DEFINES_SVH

// antecedent implies consequent on the next clock
`define GWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent on the same clock
`define GWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gwm_pkg.sv */
// ----------------------------------------------------------------------------
// gwm_pkg
// Types, constants and helper functions of the wildcard glob matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

  localparam int PAT_MAX = 128;
  localparam int POS_N   = PAT_MAX + 1;
  localparam int LEN_W   = $clog2(POS_N);
  localparam int IDX_W   = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int LVL_N   = $clog2(POS_N);

  localparam int ACT_W  = 2;
  localparam int PIDX_W = 7;
  localparam int CHAR_W = 16;
  localparam int CFG_W  = 8;

  localparam logic [CHAR_W-1:0] SYM_STAR = 16'h002A;
  localparam logic [CHAR_W-1:0] SYM_ANY  = 16'h003F;
  localparam logic [CHAR_W-1:0] SYM_UA   = 16'h0041;
  localparam logic [CHAR_W-1:0] SYM_UZ   = 16'h005A;
  localparam logic [CHAR_W-1:0] FOLD_ADD = 16'd32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PAT   = 2'd0,
    ACT_SUBJ  = 2'd1,
    ACT_EMPTY = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef logic [POS_N-1:0]  pos_t;
  typedef logic [CHAR_W-1:0] char_t;

  // fold A..Z to lower case only
  function automatic char_t fold_char(char_t c);
    return ((c >= SYM_UA) && (c <= SYM_UZ)) ? char_t'(c + FOLD_ADD) : c;
  endfunction

  // Star closure as a parallel prefix: prop[j] lets position j-1 pass into j.
  function automatic pos_t close_stars(pos_t s, pos_t prop);
    pos_t g;
    pos_t p;
    pos_t g_n;
    pos_t p_n;
    g = s;
    p = prop;
    for (int lv = 0; lv < LVL_N; lv++) begin
      g_n = g;
      p_n = p;
      for (int j = 0; j < POS_N; j++) begin
        if (j >= (1 << lv)) begin
          g_n[j] = g[j] | (p[j] & g[j - (1 << lv)]);
          p_n[j] = p[j] & p[j - (1 << lv)];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gwm_if.sv */
// ----------------------------------------------------------------------------
// gwm_if
// Valid/ready channel interfaces of the wildcard glob matcher.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwm_in_if;
  logic                         valid;
  logic                         ready;
  logic [gwm_pkg::ACT_W-1:0]    action;
  logic [gwm_pkg::PIDX_W-1:0]   pattern_index;
  logic [gwm_pkg::CHAR_W-1:0]   character;
  logic                         last_char;

  modport source (output valid, action, pattern_index, character, last_char,
                  input ready);
  modport sink   (input valid, action, pattern_index, character, last_char,
                  output ready);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

interface gwm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [gwm_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/glob_wildcard_match.sv */
// ----------------------------------------------------------------------------
// glob_wildcard_match
// Wildcard ('*', '?') matcher, 16-bit chars, one char a clock unless stalled.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | action, pattern_index, character, last_char
//  out_ch   | out | matched (after last subject char or empty-subject req)
//  cfg_ch   | in  | pattern_length, always ready
//
//  One transaction a clock while in_ch.ready is high: the active-position
//  set updates through two prefix closure networks; the result sits in the
//  output register from the cycle after the final transaction.
//  in_ch.ready drops only while a result waits and out_ch.ready is low.
//  Reset: pattern length 0, only position zero active; pattern store is
//  not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_match (
  input  wire        clk,
  input  wire        rst_n,
  gwm_in_if.sink     in_ch,
  gwm_out_if.source  out_ch,
  gwm_cfg_if.sink    cfg_ch
);
  import gwm_pkg::*;

  logic [CFG_W-1:0]  cfg_len_r;
  pos_t              act_r, act_nxt;
  char_t             pat_r  [PAT_MAX];
  logic [PAT_MAX-1:0] star_r;
  logic [PAT_MAX-1:0] any_r;
  logic              out_vld_r, out_vld_nxt;
  logic              matched_r, matched_nxt;

  logic              in_acc;
  act_t              act;
  logic [LEN_W-1:0]  len_eff;
  pos_t              in_len;
  logic [PAT_MAX-1:0] below_len;
  pos_t              prop;
  pos_t              cur_raw, cur, nxt_raw, nxt;
  char_t             ch_fold;
  logic              emit;

  assign in_ch.ready  = !out_vld_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign act          = act_t'(in_ch.action);
  assign ch_fold      = fold_char(in_ch.character);

  assign out_ch.valid   = out_vld_r;
  assign out_ch.matched = matched_r;

  always_comb begin
    len_eff = (int'(cfg_len_r) > PAT_MAX) ? LEN_W'(PAT_MAX) : LEN_W'(cfg_len_r);
    for (int j = 0; j < POS_N; j++) begin
      in_len[j] = (LEN_W'(j) <= len_eff);
    end
    for (int j = 0; j < PAT_MAX; j++) begin
      below_len[j] = (LEN_W'(j) < len_eff);
    end
    prop[0] = 1'b0;
    for (int j = 0; j < PAT_MAX; j++) begin
      prop[j+1] = star_r[j] & below_len[j];
    end

    cur_raw = (act == ACT_EMPTY) ? POS_N'(1) : (act_r & in_len);
    cur     = close_stars(cur_raw, prop);

    nxt_raw = '0;
    for (int i = 0; i < PAT_MAX; i++) begin
      if (cur[i] && below_len[i]) begin
        if (star_r[i]) begin
          nxt_raw[i] = 1'b1;
        end else if (any_r[i] || (pat_r[i] == ch_fold)) begin
          nxt_raw[i+1] = 1'b1;
        end
      end
    end
    nxt = close_stars(nxt_raw, prop);
  end

  always_comb begin
    act_nxt     = act_r;
    emit        = 1'b0;
    matched_nxt = matched_r;
    unique case (act)
      ACT_SUBJ: begin
        if (in_ch.last_char) begin
          emit        = 1'b1;
          matched_nxt = nxt[len_eff];
          act_nxt     = POS_N'(1);
        end else begin
          act_nxt = nxt;
        end
      end
      ACT_EMPTY: begin
        emit        = 1'b1;
        matched_nxt = cur[len_eff];
        act_nxt     = POS_N'(1);
      end
      ACT_PAT, ACT_NONE: begin
        act_nxt = act_r;
      end
    endcase
    if (!in_acc) begin
      act_nxt     = act_r;
      emit        = 1'b0;
      matched_nxt = matched_r;
    end
    out_vld_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= '0;
      act_r     <= POS_N'(1);
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cfg_len_r <= cfg_ch.data;
      end
      act_r     <= act_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    matched_r <= matched_nxt;
  end

  // pattern store: folded symbol plus decoded wildcard flags, no reset
  always_ff @(posedge clk) begin
    if (in_acc && (act == ACT_PAT) && (int'(in_ch.pattern_index) < PAT_MAX)) begin
      pat_r[IDX_W'(in_ch.pattern_index)]  <= ch_fold;
      star_r[IDX_W'(in_ch.pattern_index)] <= (in_ch.character == SYM_STAR);
      any_r[IDX_W'(in_ch.pattern_index)]  <= (in_ch.character == SYM_ANY);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gwm_checker.sv */
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level assertions for glob_wildcard_match, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glob_wildcard_match_defines.svh"

module gwm_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire [gwm_pkg::ACT_W-1:0]   in_action,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire                        out_matched
);
  import gwm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // an empty-subject transaction always yields a result next cycle
  `GWM_ASSERT_NXT(a_empty_res, clk, rst_n, in_acc && (in_action == ACT_EMPTY), out_valid, "empty-subject transaction gave no result")

  // a pattern write never invents a result
  `GWM_ASSERT_NXT(a_pat_quiet, clk, rst_n, in_acc && (in_action == ACT_PAT) && !out_valid, !out_valid, "pattern write produced a result")

  // no input taken while a result is stuck in the output register
  `GWM_ASSERT_NOW(a_no_ovf, clk, rst_n, out_valid && !out_ready, !in_ready, "input accepted while output stalled")

  // a stalled result holds
  `GWM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_matched), "stalled result changed")

endmodule

bind glob_wildcard_match gwm_checker u_gwm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_action   (in_ch.action),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_matched (out_ch.matched)
);

`default_nettype wire

/* bench/glob_wildcard_match_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_wildcard_match_tb
// Self-checking bench for the wildcard glob matcher. A scoreboard class keeps
// its own pattern, length and live-position set, predicts the verdict of each
// subject as its transactions are accepted, and checks every result in order.
// Directed cases come first, then phases of random lengths and patterns whose
// subjects are mostly shaped to fit the pattern, with noise, random idling on
// both sides and one long back-pressure hold.
// ----------------------------------------------------------------------------

module glob_wildcard_match_tb;
  import gwm_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int RANDOM_ITEMS    = 1050;
  localparam int CALM_AFTER      = 900;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int REPORT_MAX      = 40;

  class glob_verdict_board;
    char_t pat_mem [PAT_MAX];
    pos_t  live;
    int unsigned len_reg;
    bit    verdict_q [$];
    int    errors;

    function new();
      foreach (pat_mem[i]) pat_mem[i] = '0;
      live    = pos_t'(1);
      len_reg = 0;
      errors  = 0;
    endfunction

    function int unsigned span();
      return (len_reg > PAT_MAX) ? PAT_MAX : len_reg;
    endfunction

    function char_t lower(char_t c);
      return (c >= SYM_UA && c <= SYM_UZ) ? char_t'(c + FOLD_ADD) : c;
    endfunction

    // a live star makes the next position live too; chains through runs of stars
    function pos_t spread(pos_t s, int unsigned n);
      for (int i = 0; i < n; i++)
        if (s[i] && pat_mem[i] == SYM_STAR) s[i + 1] = 1'b1;
      return s;
    endfunction

    function void note_length(logic [CFG_W-1:0] v);
      len_reg = v;
    endfunction

    function void note_item(act_t a, logic [PIDX_W-1:0] idx, char_t ch, logic last);
      int unsigned n;
      pos_t cur;
      pos_t nxt;
      n = span();
      case (a)
        ACT_PAT: pat_mem[idx] = ch;
        ACT_EMPTY: begin
          cur = spread(pos_t'(1), n);
          verdict_q.push_back(cur[n]);
          live = pos_t'(1);
        end
        ACT_SUBJ: begin
          cur = live;
          for (int i = n + 1; i < POS_N; i++) cur[i] = 1'b0;
          cur = spread(cur, n);
          nxt = '0;
          for (int i = 0; i < n; i++) begin
            if (cur[i]) begin
              if (pat_mem[i] == SYM_STAR) nxt[i] = 1'b1;
              else if (pat_mem[i] == SYM_ANY || lower(pat_mem[i]) == lower(ch))
                nxt[i + 1] = 1'b1;
            end
          end
          nxt = spread(nxt, n);
          if (last) begin
            verdict_q.push_back(nxt[n]);
            live = pos_t'(1);
          end else begin
            live = nxt;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_verdict(logic got);
      bit want;
      if (verdict_q.size() == 0) begin
        report($sformatf("result matched=%b with none predicted", got));
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) report($sformatf("matched=%b, predicted %b", got, want));
      end
    endtask

    task flag_leftovers();
      if (verdict_q.size() != 0)
        report($sformatf("%0d predicted results never arrived", verdict_q.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;

  gwm_in_if  in_bus ();
  gwm_out_if out_bus ();
  gwm_cfg_if cfg_bus ();

  glob_wildcard_match i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  glob_verdict_board board;
  bit          calm;
  bit          hold_req;
  int          gap_odds;
  int          stall_odds;
  int unsigned item_count;
  bit          written [PAT_MAX];
  char_t       subj_buf [$];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int idle_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 2;
      default: return 6;
    endcase
  endfunction

  function automatic char_t pick_sym(bit for_pattern);
    if (for_pattern && $urandom_range(0, 2) == 0)
      return ($urandom_range(0, 1) == 0) ? SYM_STAR : SYM_ANY;
    // letters of both cases, the codes either side of A..Z, and the extremes
    case ($urandom_range(0, 11))
      0:       return 16'h0061;
      1:       return 16'h0062;
      2:       return 16'h0041;
      3:       return 16'h0042;
      4:       return 16'h005A;
      5:       return 16'h007A;
      6:       return 16'h0040;
      7:       return 16'h005B;
      8:       return 16'h0000;
      9:       return 16'hFFFF;
      10:      return SYM_STAR;
      default: return char_t'($urandom);
    endcase
  endfunction

  task automatic send_item(act_t a, logic [PIDX_W-1:0] idx, char_t ch, logic last);
    @(negedge clk);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.action        <= a;
    in_bus.pattern_index <= idx;
    in_bus.character     <= ch;
    in_bus.last_char     <= last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    board.note_item(a, idx, ch, last);
    if (a == ACT_PAT) written[idx] = 1'b1;
    if (a != ACT_NONE) item_count++;
  endtask

  task automatic send_stray();
    int unsigned n;
    n = board.span();
    case ($urandom_range(0, 3))
      0: send_item(ACT_PAT, PIDX_W'($urandom), char_t'($urandom), 1'($urandom));
      1: send_item(ACT_PAT, PIDX_W'((n != 0) ? $urandom_range(0, n - 1) : 0),
                   pick_sym(1'b1), 1'($urandom));
      2: send_item(ACT_NONE, PIDX_W'($urandom), char_t'($urandom), 1'($urandom));
      default: send_item(ACT_EMPTY, PIDX_W'($urandom), char_t'($urandom), 1'($urandom));
    endcase
  endtask

  task automatic send_subject();
    if (subj_buf.size() == 0) begin
      send_item(ACT_EMPTY, PIDX_W'($urandom), char_t'($urandom), 1'($urandom));
    end else begin
      for (int i = 0; i < subj_buf.size(); i++) begin
        if (i != 0 && $urandom_range(0, 29) == 0) send_stray();
        send_item(ACT_SUBJ, PIDX_W'($urandom), subj_buf[i], i == subj_buf.size() - 1);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (board.verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_length(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    board.note_length(v);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold when asked for
  initial begin : result_side
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) board.check_verdict(out_bus.matched);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int kind;
    int slot;
    int unsigned n;
    int unsigned subjects;
    logic [CFG_W-1:0] len_val;
    char_t p;

    board      = new();
    calm       = 1'b0;
    hold_req   = 1'b0;
    gap_odds   = 3;
    stall_odds = 3;
    item_count = 0;
    foreach (written[i]) written[i] = 1'b0;

    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.action        <= ACT_PAT;
    in_bus.pattern_index <= '0;
    in_bus.character     <= '0;
    in_bus.last_char     <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.data         <= '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero length: only the empty subject matches; the unused action is dropped
    send_item(ACT_EMPTY, '0, '0, 1'b0);
    send_item(ACT_SUBJ, '0, 16'h0061, 1'b1);
    send_item(ACT_NONE, 7'h7F, 16'hFFFF, 1'b1);
    // pattern: A * ? NUL z
    send_item(ACT_PAT, 7'd0, SYM_UA, 1'b0);
    send_item(ACT_PAT, 7'd1, SYM_STAR, 1'b1);
    send_item(ACT_PAT, 7'd2, SYM_ANY, 1'b0);
    send_item(ACT_PAT, 7'd3, 16'h0000, 1'b0);
    send_item(ACT_PAT, 7'd4, 16'h007A, 1'b0);
    set_length(8'd5);
    send_item(ACT_SUBJ, 7'h7F, 16'h0061, 1'b0);
    send_item(ACT_SUBJ, '0, 16'hFFFF, 1'b0);
    send_item(ACT_SUBJ, '0, 16'h0000, 1'b0);
    send_item(ACT_SUBJ, '0, SYM_UZ, 1'b1);
    // empty-subject request abandons the open subject
    send_item(ACT_SUBJ, '0, 16'h0061, 1'b0);
    send_item(ACT_EMPTY, '0, '0, 1'b1);
    // pattern rewritten mid-subject; '[' and '{' must not fold together
    send_item(ACT_SUBJ, '0, 16'h0061, 1'b0);
    send_item(ACT_PAT, 7'd4, 16'h005B, 1'b0);
    send_item(ACT_SUBJ, '0, 16'h0040, 1'b0);
    send_item(ACT_SUBJ, '0, 16'h0000, 1'b0);
    send_item(ACT_SUBJ, '0, 16'h007B, 1'b1);
    send_item(ACT_SUBJ, '0, 16'h0061, 1'b0);
    send_item(ACT_SUBJ, '0, 16'h0040, 1'b0);
    send_item(ACT_SUBJ, '0, 16'h0000, 1'b0);
    send_item(ACT_SUBJ, '0, 16'h005B, 1'b1);

    item_count = 0;
    phase      = 0;
    while (item_count < RANDOM_ITEMS) begin
      calm       = (item_count >= CALM_AFTER);
      gap_odds   = idle_odds();
      stall_odds = idle_odds();
      case (phase)
        2: len_val = 8'd255;
        7: len_val = 8'd128;
        default: begin
          if ($urandom_range(0, 9) == 0)
            len_val = '0;
          else
            len_val = CFG_W'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 8));
        end
      endcase
      n = (len_val > PAT_MAX) ? PAT_MAX : len_val;

      // never let a live position reach a store entry that was not written
      wait_idle();
      for (int i = 0; i < n; i++)
        if (!written[i] || n <= 20)
          send_item(ACT_PAT, PIDX_W'(i), pick_sym(1'b1), 1'($urandom));
      set_length(len_val);
      if (phase == 4) hold_req = 1'b1;

      subjects = (n > 20) ? 1 : $urandom_range(3, 10);
      repeat (subjects) begin
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          // walk the pattern so most subjects get deep; some get damaged
          subj_buf.delete();
          for (int i = 0; i < n; i++) begin
            p = board.pat_mem[i];
            if (p == SYM_STAR) begin
              repeat ($urandom_range(0, 3)) subj_buf.push_back(pick_sym(1'b0));
            end else if (p == SYM_ANY) begin
              subj_buf.push_back(pick_sym(1'b0));
            end else if ($urandom_range(0, 1) == 0 && p >= SYM_UA && p <= SYM_UZ) begin
              subj_buf.push_back(p + FOLD_ADD);
            end else if ($urandom_range(0, 1) == 0 && p >= SYM_UA + FOLD_ADD
                         && p <= SYM_UZ + FOLD_ADD) begin
              subj_buf.push_back(p - FOLD_ADD);
            end else begin
              subj_buf.push_back(p);
            end
          end
          if ($urandom_range(0, 3) == 0) begin
            slot = $urandom_range(0, subj_buf.size());
            case ($urandom_range(0, 2))
              0: subj_buf.insert(slot, pick_sym(1'b0));
              1: if (slot < subj_buf.size()) subj_buf.delete(slot);
              default: if (slot < subj_buf.size()) subj_buf[slot] = pick_sym(1'b0);
            endcase
          end
          send_subject();
        end else if (kind == 7) begin
          send_stray();
        end else if (kind == 8) begin
          subj_buf.delete();
          repeat ($urandom_range(1, 6)) subj_buf.push_back(char_t'($urandom));
          send_subject();
        end else begin
          send_item(ACT_EMPTY, PIDX_W'($urandom), char_t'($urandom), 1'($urandom));
        end
      end

      // sometimes carry an open subject across the next length change
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          send_item(ACT_SUBJ, PIDX_W'($urandom), pick_sym(1'b0), 1'b0);
      phase++;
    end

    wait_idle();
    board.flag_leftovers();
    if (board.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/gwm_pkg.sv
rtl/core/gwm_if.sv
rtl/core/glob_wildcard_match.sv
rtl/core/gwm_checker.sv
bench/glob_wildcard_match_tb.sv
